### src/polynomial_multiplier_assert.svh
// ----------------------------------------------------------------------------
// Polynomial multiplier assertion macros
// Shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_MULTIPLIER_ASSERT_SVH
`define POLYNOMIAL_MULTIPLIER_ASSERT_SVH

// same-cycle implication under reset
`define PM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define PM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/polymul_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial multiplier package
// Sizes, sequencer states and pipeline tag type shared by the design.
// ----------------------------------------------------------------------------
package polymul_pkg;

  localparam int MAX_TERMS = 32;
  localparam int COEF_BITS = 16;
  localparam int ACC_W     = 37;
  localparam int DEG_W     = 6;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int PROD_W    = 2 * COEF_BITS;
  localparam int K_W       = DEG_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN
  } polymul_state_e;

  // tag carried alongside each product through the pipeline
  typedef struct packed {
    logic             first;
    logic             last;
    logic             final_res;
    logic [DEG_W-1:0] degree;
  } polymul_tag_t;

endpackage

### src/polymul_if.sv
// ----------------------------------------------------------------------------
// Polynomial multiplier channels
// Valid/ready channels for coefficient pairs in and product terms out.
// ----------------------------------------------------------------------------
interface polymul_in_if import polymul_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [COEF_BITS-1:0] coef_a;
  logic signed [COEF_BITS-1:0] coef_b;
  logic                        last;

  modport source (output valid, output coef_a, output coef_b, output last, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input last, output ready);
endinterface

interface polymul_out_if import polymul_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] coef;
  logic [DEG_W-1:0]        degree;
  logic                    final_res;
  logic                    dropped;

  modport source (output valid, output coef, output degree, output final_res,
                  output dropped, input ready);
  modport sink   (input valid, input coef, input degree, input final_res,
                  input dropped, output ready);
endinterface

### src/polynomial_multiplier.sv
// Loading: coefficient pairs are accepted back to back while idle; the first product
//   term passes the read, product and output registers after the beat marked last.
// Throughput: the shared multiply-accumulate unit takes one product per cycle unless the
//   output stalls, so a load of n pairs costs n*n products plus the pipeline drain.
// Reset: control state clears asynchronously; coefficient stores are not cleared.
// ----------------------------------------------------------------------------
// Polynomial multiplier
// Schoolbook product of two coefficient vectors on one pipelined multiplier,
// one output coefficient accumulated at a time.
// ----------------------------------------------------------------------------
module polynomial_multiplier import polymul_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  polymul_in_if.sink    in_i,
  polymul_out_if.source out_o
);

  // coefficient stores
  logic signed [COEF_BITS-1:0] mem_a [MAX_TERMS];
  logic signed [COEF_BITS-1:0] mem_b [MAX_TERMS];

  polymul_state_e state_q, state_d;
  logic [CNT_W-1:0] load_cnt_q, n_q;
  logic             ovf_q, dropped_q;
  logic [DEG_W-1:0] k_q;
  logic [IDX_W-1:0] i_q;

  logic in_ready, issue, adv, in_acc, store_ok;

  // pipeline
  logic                        v1_q, v2_q;
  polymul_tag_t                tag_is, tag1_q, tag2_q;
  logic signed [COEF_BITS-1:0] rd_a_q, rd_b_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     acc_q, acc_d;

  // output register
  logic                    out_valid_q;
  logic signed [ACC_W-1:0] out_coef_q;
  logic [DEG_W-1:0]        out_deg_q;
  logic                    out_final_q, out_drop_q;

  // index arithmetic
  logic [K_W-1:0]   n_ext, k_ext, k_nxt, i_ext, i_hi, i_lo, lo_nxt, j_ext;
  logic             at_hi, k_end;
  logic [IDX_W-1:0] j_idx;

  assign in_acc   = in_i.valid && in_ready;
  assign store_ok = (load_cnt_q < CNT_W'(MAX_TERMS));
  assign adv      = !out_valid_q || out_o.ready;

  assign n_ext  = K_W'(n_q);
  assign k_ext  = K_W'(k_q);
  assign i_ext  = K_W'(i_q);
  assign k_nxt  = k_ext + K_W'(1);
  assign i_hi   = (k_ext >= n_ext - K_W'(1)) ? n_ext - K_W'(1) : k_ext;
  assign i_lo   = (k_ext >= n_ext) ? k_ext - n_ext + K_W'(1) : '0;
  assign lo_nxt = (k_nxt >= n_ext) ? k_nxt - n_ext + K_W'(1) : '0;
  assign j_ext  = k_ext - i_ext;
  assign j_idx  = j_ext[IDX_W-1:0];
  assign at_hi  = (i_ext == i_hi);
  assign k_end  = (k_ext == (n_ext << 1) - K_W'(2));

  // tag for the product issued this cycle
  always_comb begin
    tag_is.first     = (i_ext == i_lo);
    tag_is.last      = at_hi;
    tag_is.final_res = at_hi && k_end;
    tag_is.degree    = k_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.last) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (adv && at_hi && k_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_CALC:  issue    = 1'b1;
      ST_DRAIN: begin
        in_ready = 1'b0;
        issue    = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
        issue    = 1'b0;
      end
    endcase
  end

  // hold state, load count, overflow flag, length, drop flag and product indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      load_cnt_q <= '0;
      ovf_q      <= 1'b0;
      n_q        <= '0;
      dropped_q  <= 1'b0;
      k_q        <= '0;
      i_q        <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (in_i.last) begin
          n_q        <= store_ok ? load_cnt_q + CNT_W'(1) : load_cnt_q;
          dropped_q  <= ovf_q || !store_ok;
          load_cnt_q <= '0;
          ovf_q      <= 1'b0;
          k_q        <= '0;
          i_q        <= '0;
        end else if (store_ok) begin
          load_cnt_q <= load_cnt_q + CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end else if (issue && adv) begin
        // advance through i for this degree, then on to the next degree
        if (at_hi) begin
          k_q <= k_nxt[DEG_W-1:0];
          i_q <= lo_nxt[IDX_W-1:0];
        end else begin
          i_q <= i_q + IDX_W'(1);
        end
      end
    end
  end

  // write stores while loading
  always_ff @(posedge clk_i) begin
    if (in_acc && store_ok) begin
      mem_a[load_cnt_q[IDX_W-1:0]] <= in_i.coef_a;
      mem_b[load_cnt_q[IDX_W-1:0]] <= in_i.coef_b;
    end
  end

  // read stores, multiply
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (issue) begin
        rd_a_q <= mem_a[i_q];
        rd_b_q <= mem_b[j_idx];
        tag1_q <= tag_is;
      end
      if (v1_q) begin
        prod_q <= rd_a_q * rd_b_q;
        tag2_q <= tag1_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  // accumulate, restarting on the first product of each degree
  assign acc_d = (tag2_q.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      acc_q <= acc_d;
      if (tag2_q.last) begin
        out_coef_q  <= acc_d;
        out_deg_q   <= tag2_q.degree;
        out_final_q <= tag2_q.final_res;
        out_drop_q  <= dropped_q;
      end
    end
  end

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_q && tag2_q.last;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.coef      = out_coef_q;
  assign out_o.degree    = out_deg_q;
  assign out_o.final_res = out_final_q;
  assign out_o.dropped   = out_drop_q;

endmodule

### src/polymul_checker.sv
// ----------------------------------------------------------------------------
// Polynomial multiplier checker
// Port-level checks on loading and on the product beat stream.
// ----------------------------------------------------------------------------
`include "polynomial_multiplier_assert.svh"

module polymul_checker import polymul_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_last_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [ACC_W-1:0] out_coef_i,
  input logic [DEG_W-1:0]        out_degree_i,
  input logic                    out_final_i,
  input logic                    out_dropped_i
);

  // a stalled product beat holds
  `PM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_coef_i) && $stable(out_degree_i) && $stable(out_final_i) && $stable(out_dropped_i), "stalled product beat changed")

  // the final term has even degree 2n-2
  `PM_ASSERT_NOW(a_final_even, out_valid_i && out_final_i, out_degree_i[0] == 1'b0, "final term has odd degree")

  // a closing beat starts compute, so loading stops
  `PM_ASSERT_NEXT(a_close_busy, in_valid_i && in_ready_i && in_last_i, !in_ready_i, "ready after closing beat")

  // a plain load beat leaves the block ready for the next one
  `PM_ASSERT_NEXT(a_load_ready, in_valid_i && in_ready_i && !in_last_i, in_ready_i, "not ready after load beat")

endmodule

bind polynomial_multiplier polymul_checker u_polymul_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.last),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_coef_i    (out_o.coef),
  .out_degree_i  (out_o.degree),
  .out_final_i   (out_o.final_res),
  .out_dropped_i (out_o.dropped)
);

### test/tb_polynomial_multiplier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polynomial multiplier testbench
// Loads coefficient vectors of directed and random length and content, with
// random gaps on the input and random back-pressure on the output. Predicts
// each product coefficient exactly and checks every output beat in order.
// ----------------------------------------------------------------------------
module tb_polynomial_multiplier;
  import polymul_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int LIMIT       = 1000000;
  localparam int PAIR_TARGET = 410;
  localparam int CALM_FROM   = 350;
  localparam int SUM_DEPTH   = 2 * MAX_TERMS - 1;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] coef;
    logic [DEG_W-1:0]        degree;
    logic                    final_res;
    logic                    dropped;
  } product_term_t;

  // Holds the loaded vectors, forms each product and checks the terms out
  class product_ledger;
    coef_t         held_a [MAX_TERMS];
    coef_t         held_b [MAX_TERMS];
    int            held;
    bit            lost;
    int            errors;
    product_term_t expected_terms [$];

    function new();
      held   = 0;
      lost   = 0;
      errors = 0;
    endfunction

    // Store one accepted pair; on the closing pair queue the whole product
    function void note_pair(coef_t a, coef_t b, logic last);
      longint        sums [SUM_DEPTH];
      int            n;
      product_term_t t;
      if (held < MAX_TERMS) begin
        held_a[held] = a;
        held_b[held] = b;
        held++;
      end else begin
        lost = 1;
      end
      if (!last) return;
      n = held;
      foreach (sums[k]) sums[k] = 0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          sums[i + j] += longint'(held_a[i]) * longint'(held_b[j]);
        end
      end
      for (int k = 0; k < 2 * n - 1; k++) begin
        t.coef      = ACC_W'(sums[k]);
        t.degree    = DEG_W'(k);
        t.final_res = (k == 2 * n - 2);
        t.dropped   = lost;
        expected_terms.push_back(t);
      end
      held = 0;
      lost = 0;
    endfunction

    // Compare one output beat with the oldest expected term
    function void check_term(product_term_t got);
      product_term_t want;
      if (expected_terms.size() == 0) begin
        $error("unexpected product term: degree %0d coef %0d", got.degree, got.coef);
        errors++;
        return;
      end
      want = expected_terms.pop_front();
      if (got.coef !== want.coef) begin
        $error("coef: expected %0d, got %0d", want.coef, got.coef);
        errors++;
      end
      if (got.degree !== want.degree) begin
        $error("degree: expected %0d, got %0d", want.degree, got.degree);
        errors++;
      end
      if (got.final_res !== want.final_res) begin
        $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
        errors++;
      end
    endfunction

    function int pending();
      return expected_terms.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  polymul_in_if  pair_bus ();
  polymul_out_if term_bus ();

  polynomial_multiplier uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pair_bus),
    .out_o  (term_bus)
  );

  product_ledger ledger;
  int            pairs_sent;
  int            src_idle_pct;
  int            sink_idle_pct;
  bit            calm;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Cycle limit
  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // Drive one coefficient pair, with an optional gap in front of it
  task automatic send_pair(coef_t a, coef_t b, logic last);
    if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
      pair_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    pair_bus.valid  <= 1'b1;
    pair_bus.coef_a <= a;
    pair_bus.coef_b <= b;
    pair_bus.last   <= last;
    @(posedge clk_i);
    while (!pair_bus.ready) @(posedge clk_i);
    ledger.note_pair(a, b, last);
    pairs_sent++;
    if (pairs_sent >= CALM_FROM) calm = 1;
  endtask

  // Pick one coefficient according to the content style of the load
  function automatic coef_t pick_coef(int style);
    coef_t edges [4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    case (style)
      0: begin
        return coef_t'($urandom);
      end
      1: begin
        return edges[$urandom_range(0, 3)];
      end
      default: begin
        return coef_t'($signed($urandom_range(0, 16)) - 8);
      end
    endcase
  endfunction

  // Send a whole load of n pairs, the last one flagged
  task automatic send_load(int n, int style);
    for (int i = 0; i < n; i++) begin
      send_pair(pick_coef(style), pick_coef(style), i == n - 1);
    end
  endtask

  // Result sink: check each accepted beat, then set ready for the next cycle
  initial begin
    int stall_left;
    int cycles;
    product_term_t got;
    stall_left     = 0;
    cycles         = 0;
    term_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (term_bus.valid && term_bus.ready) begin
        got.coef      = term_bus.coef;
        got.degree    = term_bus.degree;
        got.final_res = term_bus.final_res;
        got.dropped   = term_bus.dropped;
        ledger.check_term(got);
      end
      cycles++;
      if (cycles % 200 == 0) begin
        case ($urandom_range(0, 3))
          0, 1: sink_idle_pct = 0;
          2: sink_idle_pct = 10;
          default: sink_idle_pct = 40;
        endcase
      end
      if (calm) begin
        stall_left = 0;
        term_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        term_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        stall_left = $urandom_range(1, 6) - 1;
        term_bus.ready <= 1'b0;
      end else begin
        term_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int roll;
    int n;
    ledger          = new();
    pairs_sent      = 0;
    calm            = 0;
    src_idle_pct    = 20;
    sink_idle_pct   = 20;
    rst_ni          = 1'b0;
    pair_bus.valid  <= 1'b0;
    pair_bus.coef_a <= '0;
    pair_bus.coef_b <= '0;
    pair_bus.last   <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Single-pair loads at the extremes
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sh0000, 16'shffff, 1'b1);
    // Two and three pairs with mixed signs
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'shffff, 16'shffff, 1'b0);
    send_pair(16'sh0000, 16'sh0001, 1'b0);
    send_pair(16'sh5555, 16'shaaaa, 1'b1);

    // Full load of the most negative value: largest middle coefficient
    for (int i = 0; i < MAX_TERMS; i++) send_pair(16'sh8000, 16'sh8000, i == MAX_TERMS - 1);
    // Pair arriving on a full store, flagged last: product of the held pairs
    send_load(MAX_TERMS + 1, 1);
    // Overflow by several pairs, then a short load to see the flag clear
    send_load(MAX_TERMS + 3, 0);
    send_load(2, 0);

    // Random loads, mostly short, now and then long or overflowing
    while (pairs_sent < PAIR_TARGET) begin
      case ($urandom_range(0, 3))
        0, 1: src_idle_pct = 0;
        2: src_idle_pct = 15;
        default: src_idle_pct = 40;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 70) n = $urandom_range(1, 8);
      else if (roll < 92) n = $urandom_range(9, MAX_TERMS);
      else n = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
      send_load(n, $urandom_range(0, 2));
    end
    pair_bus.valid <= 1'b0;

    // Drain the outstanding terms, then watch for strays
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### polynomial_multiplier.f
+incdir+src
src/polymul_pkg.sv
src/polymul_if.sv
src/polynomial_multiplier.sv
src/polymul_checker.sv
test/tb_polynomial_multiplier.sv
